>>> rtl/blr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the line rasterizer.
// No dependencies; every other file in rtl/ except blr_outq refers to this package.
package blr_pkg;

  localparam int COORD_BITS_DEFAULT = 10;
  localparam int CFG_W              = 11;
  localparam int INDEX_W            = 20;
  localparam int COLOR_W            = 8;
  localparam int APB_DATA_W         = 32;
  localparam int APB_ADDR_W         = 3;

  localparam logic [CFG_W-1:0]   FRAME_RESET = 11'd400;
  localparam logic [COLOR_W-1:0] COLOR_FULL  = 8'd255;
  localparam logic [COLOR_W-1:0] COLOR_HALF  = 8'd127;
  localparam logic [COLOR_W-1:0] COLOR_NONE  = 8'd0;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } frame_cfg_t;

endpackage

>>> rtl/blr_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: line command items in, pixel items out.
// Depends on blr_pkg for default widths.
interface blr_in_if #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;
  logic                  follow_octant;

  modport source (output valid, operation, x_start, y_start, x_end, y_end, follow_octant,
                  input ready);
  modport sink   (input valid, operation, x_start, y_start, x_end, y_end, follow_octant,
                  output ready);
endinterface

interface blr_out_if #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic [COORD_BITS-1:0]         pixel_x;
  logic [COORD_BITS-1:0]         pixel_y;
  logic [blr_pkg::INDEX_W-1:0]   pixel_index;
  logic [blr_pkg::COLOR_W-1:0]   red;
  logic [blr_pkg::COLOR_W-1:0]   green;
  logic [blr_pkg::COLOR_W-1:0]   blue;
  logic                          last_pixel;
  logic                          out_of_frame;

  modport source (output valid, pixel_x, pixel_y, pixel_index, red, green, blue,
                  last_pixel, out_of_frame, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_index, red, green, blue,
                  last_pixel, out_of_frame, output ready);
endinterface

>>> rtl/bresenham_line_rasterizer_top.sv
`timescale 1ns / 1ps
// Bresenham line rasterizer top: APB frame registers, line core, output stage.
// Pixel items are registered in the output stage (result or skid register).
// Throughput: one item per cycle while the skid register is free; the single
//   add-compare error update in blr_core and the combinational index multiply set it.
// Reset: synchronous, active high; clears the active line and the output stage and
//   sets frame width and height to 400. No clearing pass.
module bresenham_line_rasterizer_top #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [blr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [blr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [blr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  // item channels
  blr_in_if.sink                            in_ch,
  blr_out_if.source                         out_ch
);
  import blr_pkg::*;

  localparam int RES_W = 2 * COORD_BITS + INDEX_W + 3 * COLOR_W + 2;

  frame_cfg_t cfg;
  reg_idx_t   reg_sel;
  logic       cfg_write;

  logic                  accept;
  logic                  res_push;
  logic [COORD_BITS-1:0] res_x, res_y;
  logic [INDEX_W-1:0]    res_index;
  logic [COLOR_W-1:0]    res_red, res_green, res_blue;
  logic                  res_last, res_outside;
  logic [RES_W-1:0]      q_data;

  // Register index is the word address; byte offset bits are ignored.
  assign reg_sel   = reg_idx_t'(paddr[2]);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= FRAME_RESET;
      cfg.height <= FRAME_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:  cfg.width  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: cfg.height <= pwdata[CFG_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(cfg.width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg.height);
      default:          prdata = '0;
    endcase
  end

  // An item is taken whenever the skid register is free; start items and
  // advances with no active line are absorbed by the core and produce nothing.
  assign accept = in_ch.valid && in_ch.ready;

  blr_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .operation     (in_ch.operation),
    .x_start       (in_ch.x_start),
    .y_start       (in_ch.y_start),
    .x_end         (in_ch.x_end),
    .y_end         (in_ch.y_end),
    .follow_octant (in_ch.follow_octant),
    .cfg           (cfg),
    .res_push      (res_push),
    .res_x         (res_x),
    .res_y         (res_y),
    .res_index     (res_index),
    .res_red       (res_red),
    .res_green     (res_green),
    .res_blue      (res_blue),
    .res_last      (res_last),
    .res_outside   (res_outside)
  );

  // Result register with a skid entry behind it, so a stalled sink does not
  // stop the item arriving in the same cycle.
  blr_outq #(
    .W (RES_W)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data ({res_x, res_y, res_index, res_red, res_green, res_blue,
                 res_last, res_outside}),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (q_data)
  );

  assign {out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_index, out_ch.red, out_ch.green,
          out_ch.blue, out_ch.last_pixel, out_ch.out_of_frame} = q_data;

endmodule

>>> rtl/blr_core.sv
`timescale 1ns / 1ps
// Line state registers and combinational pixel datapath (setup and step).
// Depends on blr_pkg.
module blr_core #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         operation,
  input  logic [COORD_BITS-1:0]        x_start,
  input  logic [COORD_BITS-1:0]        y_start,
  input  logic [COORD_BITS-1:0]        x_end,
  input  logic [COORD_BITS-1:0]        y_end,
  input  logic                         follow_octant,
  input  blr_pkg::frame_cfg_t          cfg,
  output logic                         res_push,
  output logic [COORD_BITS-1:0]        res_x,
  output logic [COORD_BITS-1:0]        res_y,
  output logic [blr_pkg::INDEX_W-1:0]  res_index,
  output logic [blr_pkg::COLOR_W-1:0]  res_red,
  output logic [blr_pkg::COLOR_W-1:0]  res_green,
  output logic [blr_pkg::COLOR_W-1:0]  res_blue,
  output logic                         res_last,
  output logic                         res_outside
);
  import blr_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int EW    = COORD_BITS + 3;
  localparam int CMP_W = (CB > CFG_W) ? CB : CFG_W;
  localparam int SUM_W = ((CB + CFG_W + 1) > INDEX_W) ? (CB + CFG_W + 1) : INDEX_W;

  logic                 line_active;
  logic [CB-1:0]        major_pos, major_stop, minor_pos, major_delta, minor_delta;
  logic signed [EW-1:0] decision_error;
  logic                 minor_down, is_steep, octant_mode;

  // setup path
  logic [CB:0]          diff_x, diff_y;
  logic [CB-1:0]        adx, ady;
  logic                 steep_n, swap_n;
  logic [CB-1:0]        a0, a1, b0, b1, ms, me, ns, ne, dx_n, dy_n;
  logic signed [EW-1:0] err_start;

  // step path
  logic                 upright, err_pos;
  logic [CB-1:0]        px, py, major_inc, minor_step;
  logic [SUM_W-1:0]     lin_index;
  logic signed [EW-1:0] err_next;

  always_comb begin
    diff_x = {1'b0, x_end} - {1'b0, x_start};
    diff_y = {1'b0, y_end} - {1'b0, y_start};
    adx    = diff_x[CB] ? CB'(-diff_x) : diff_x[CB-1:0];
    ady    = diff_y[CB] ? CB'(-diff_y) : diff_y[CB-1:0];
    steep_n = ady > adx;
    // exchange axes for steep lines
    a0 = steep_n ? y_start : x_start;
    b0 = steep_n ? x_start : y_start;
    a1 = steep_n ? y_end   : x_end;
    b1 = steep_n ? x_end   : y_end;
    // order endpoints so the major coordinate rises
    swap_n = a0 > a1;
    ms = swap_n ? a1 : a0;
    me = swap_n ? a0 : a1;
    ns = swap_n ? b1 : b0;
    ne = swap_n ? b0 : b1;
    dx_n = me - ms;
    dy_n = (ne >= ns) ? (ne - ns) : (ns - ne);
    err_start = $signed({2'b00, dy_n, 1'b0}) - $signed({3'b000, dx_n});
  end

  always_comb begin
    upright    = octant_mode & ~is_steep;
    px         = upright ? major_pos : minor_pos;
    py         = upright ? minor_pos : major_pos;
    major_inc  = major_pos + CB'(1);
    res_last   = major_inc == major_stop;
    res_outside = (CMP_W'(px) >= CMP_W'(cfg.width)) || (CMP_W'(py) >= CMP_W'(cfg.height));
    lin_index  = SUM_W'(py) * SUM_W'(cfg.width) + SUM_W'(px);
    res_index  = res_outside ? '0 : lin_index[INDEX_W-1:0];
    res_x      = px;
    res_y      = py;
    res_red    = COLOR_FULL;
    res_green  = upright ? COLOR_FULL : COLOR_NONE;
    res_blue   = upright ? COLOR_NONE : COLOR_HALF;
    err_pos    = decision_error > 0;
    minor_step = minor_down ? (minor_pos - CB'(1)) : (minor_pos + CB'(1));
    err_next   = decision_error + $signed({2'b00, minor_delta, 1'b0})
               - (err_pos ? $signed({2'b00, major_delta, 1'b0}) : EW'(0));
    res_push   = accept && (op_t'(operation) == OP_ADVANCE) && line_active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (accept && (op_t'(operation) == OP_START)) begin
      line_active <= dx_n != '0;
    end else if (res_push && res_last) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (op_t'(operation) == OP_START)) begin
      is_steep       <= steep_n;
      major_pos      <= ms;
      major_stop     <= me;
      minor_pos      <= ns;
      minor_down     <= !(ns < ne);
      major_delta    <= dx_n;
      minor_delta    <= dy_n;
      decision_error <= err_start;
      octant_mode    <= follow_octant;
    end else if (res_push) begin
      major_pos      <= major_inc;
      decision_error <= err_next;
      if (err_pos) begin
        minor_pos <= minor_step;
      end
    end
  end

endmodule

>>> rtl/blr_outq.sv
`timescale 1ns / 1ps
// Two-entry output stage: result register plus skid register.
// No dependencies; generic in width.
module blr_outq #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         pop;

  assign pop      = out_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

>>> rtl/blr_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the rasterizer top, attached by the bind below.
// Depends on blr_pkg and bresenham_line_rasterizer_top.
module blr_checker #(
  parameter int COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [COORD_BITS-1:0]       pixel_x,
  input logic [COORD_BITS-1:0]       pixel_y,
  input logic [blr_pkg::INDEX_W-1:0] pixel_index,
  input logic                        last_pixel,
  input logic                        out_of_frame
);
  import blr_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_room_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_outside_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_frame) |-> (pixel_index == '0))
    else $error("nonzero index on out-of-frame pixel");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output item dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(pixel_x) && $stable(pixel_y)
                                   && $stable(last_pixel)))
    else $error("output item changed while stalled");

endmodule

bind bresenham_line_rasterizer_top blr_checker #(
  .COORD_BITS (COORD_BITS)
) u_blr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pixel_x      (out_ch.pixel_x),
  .pixel_y      (out_ch.pixel_y),
  .pixel_index  (out_ch.pixel_index),
  .last_pixel   (out_ch.last_pixel),
  .out_of_frame (out_ch.out_of_frame)
);

>>> tb/tb_bresenham_line_rasterizer_top.sv
`timescale 1ns / 1ps
// Self-checking bench for bresenham_line_rasterizer_top: random line commands in,
// pixel items checked against an in-bench rasterizer model. Needs blr_pkg, blr_ifs, RTL top.
module tb_bresenham_line_rasterizer_top;
  import blr_pkg::*;

  localparam int CB           = COORD_BITS_DEFAULT;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 200000;

  // One command item as the sender holds it.
  typedef struct packed {
    op_t           op;
    logic [CB-1:0] x_start;
    logic [CB-1:0] y_start;
    logic [CB-1:0] x_end;
    logic [CB-1:0] y_end;
    logic          follow;
  } line_cmd_t;

  // One pixel item as the block should emit it.
  typedef struct packed {
    logic [CB-1:0]      px;
    logic [CB-1:0]      py;
    logic [INDEX_W-1:0] idx;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
    logic               oof;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic                  psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;

  blr_in_if  #(.COORD_BITS(CB)) in_ch ();
  blr_out_if #(.COORD_BITS(CB)) out_ch ();

  bresenham_line_rasterizer_top #(.COORD_BITS(CB)) u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  always #5 clk = ~clk;

  // Command items waiting to be offered, and pixels the model says are still owed.
  line_cmd_t line_cmds[$];
  pixel_t    pixels_due[$];

  int errors = 0;
  int cycles = 0;
  int src_idle_pct = 14;  // percent of cycles the sender holds back
  int snk_idle_pct = 78;  // percent of cycles the receiver drops ready
  logic hold_start = 1'b0;
  int hold_left;

  // Model copy of the frame registers.
  logic [CFG_W-1:0] frame_w = FRAME_RESET;
  logic [CFG_W-1:0] frame_h = FRAME_RESET;

  // Model copy of the line walker.
  logic                line_on;
  logic [CB-1:0]       maj_pos, maj_stop, min_pos, maj_d, min_d;
  logic signed [12:0]  err_term;
  logic                min_down, steep, octant;

  // Latch a new line: transpose steep lines, order by the major axis, seed 2*dy - dx.
  function automatic void raster_begin(input line_cmd_t c);
    logic [CB-1:0] sx, sy, ex, ey, t, adx, ady;
    sx = c.x_start;
    sy = c.y_start;
    ex = c.x_end;
    ey = c.y_end;
    adx = (ex > sx) ? ex - sx : sx - ex;
    ady = (ey > sy) ? ey - sy : sy - ey;
    steep = ady > adx;
    if (steep) begin
      t = sx; sx = sy; sy = t;
      t = ex; ex = ey; ey = t;
    end
    if (sx > ex) begin
      t = sx; sx = ex; ex = t;
      t = sy; sy = ey; ey = t;
    end
    min_down = !(sy < ey);
    maj_d    = ex - sx;
    min_d    = (ey > sy) ? ey - sy : sy - ey;
    maj_pos  = sx;
    maj_stop = ex;
    min_pos  = sy;
    err_term = $signed({2'b00, min_d, 1'b0}) - $signed({3'b000, maj_d});
    octant   = c.follow;
    line_on  = maj_d != '0;
  endfunction

  // Emit the current pixel into the expectation queue, then take one Bresenham step.
  function automatic void raster_advance();
    pixel_t        p;
    logic [CB-1:0] x, y;
    logic          upright;
    logic [31:0]   lin;
    if (!line_on) return;
    upright = octant && !steep;
    x = upright ? maj_pos : min_pos;
    y = upright ? min_pos : maj_pos;
    lin = y * frame_w + x;
    p.px    = x;
    p.py    = y;
    p.oof   = ({1'b0, x} >= frame_w) || ({1'b0, y} >= frame_h);
    p.idx   = p.oof ? '0 : lin[INDEX_W-1:0];
    p.red   = COLOR_FULL;
    p.green = upright ? COLOR_FULL : COLOR_NONE;
    p.blue  = upright ? COLOR_NONE : COLOR_HALF;
    p.last  = (maj_pos + 1'b1) == maj_stop;
    pixels_due.push_back(p);
    if (err_term > 0) begin
      min_pos  = min_down ? min_pos - 1'b1 : min_pos + 1'b1;
      err_term = err_term - $signed({2'b00, maj_d, 1'b0});
    end
    err_term = err_term + $signed({2'b00, min_d, 1'b0});
    maj_pos  = maj_pos + 1'b1;
    if (p.last) line_on = 1'b0;
  endfunction

  // Random filler everywhere; callers overwrite the fields that matter.
  function automatic line_cmd_t rand_cmd(input op_t op);
    line_cmd_t c;
    c.op      = op;
    c.x_start = CB'($urandom);
    c.y_start = CB'($urandom);
    c.x_end   = CB'($urandom);
    c.y_end   = CB'($urandom);
    c.follow  = 1'($urandom);
    return c;
  endfunction

  task automatic push_start(input int xs, ys, xe, ye, input logic follow);
    line_cmd_t c;
    c = rand_cmd(OP_START);
    c.x_start = CB'(xs);
    c.y_start = CB'(ys);
    c.x_end   = CB'(xe);
    c.y_end   = CB'(ye);
    c.follow  = follow;
    line_cmds.push_back(c);
  endtask

  task automatic push_advances(input int n);
    repeat (n) line_cmds.push_back(rand_cmd(OP_ADVANCE));
  endtask

  // Mostly whole lines with random endpoints; some abandoned, some overrun, some noise.
  task automatic fill_items(input int n);
    line_cmd_t c;
    int        done_n, pick, len, mn, dx, dy, xs, ys, xe, ye, adv;
    done_n = 0;
    while (done_n < n) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        c = rand_cmd(op_t'($urandom_range(1)));
        line_cmds.push_back(c);
        if (c.op == OP_START) done_n++;
      end else if (pick < 9) begin
        // long line across the whole coordinate range, cut off early
        push_start($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(1023), 1'($urandom));
        adv = $urandom_range(1, 30);
        push_advances(adv);
        done_n += 1 + adv;
      end else begin
        len = ($urandom_range(19) == 0) ? $urandom_range(25, 160) : $urandom_range(16);
        // trim the last line so the phase lands near its item count
        if (len > n - done_n) len = n - done_n;
        mn  = $urandom_range(len);
        if ($urandom_range(1)) begin
          dx = mn; dy = len;
        end else begin
          dx = len; dy = mn;
        end
        xs = $urandom_range(1023);
        ys = $urandom_range(1023);
        xe = (($urandom_range(1) && xs >= dx) || xs + dx > 1023) ? xs - dx : xs + dx;
        ye = (($urandom_range(1) && ys >= dy) || ys + dy > 1023) ? ys - dy : ys + dy;
        push_start(xs, ys, xe, ye, 1'($urandom));
        pick = $urandom_range(9);
        if (pick == 0) adv = len + $urandom_range(1, 3);
        else if (pick == 1) adv = $urandom_range(len);
        else adv = len;
        push_advances(adv);
        done_n += 1 + ((adv < len) ? adv : len);
      end
    end
  endtask

  // Two-phase APB write; the register takes the value on the access edge.
  task automatic write_reg(input reg_idx_t r, input logic [CFG_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_FRAME_WIDTH) frame_w = v;
    else frame_h = v;
  endtask

  // Let the sender run dry, then wait out every owed pixel plus the pipeline tail.
  task automatic drain();
    while (line_cmds.size() != 0 || in_ch.valid) @(negedge clk);
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input int n, input logic with_hold);
    fill_items(n / 2);
    drain();
    if (with_hold) begin
      // receiver goes quiet while the sender keeps pushing
      hold_start = 1'b1;
      @(negedge clk);
      hold_start = 1'b0;
    end
    fill_items(n - n / 2);
    drain();
  endtask

  // Sender: predict on every accepted item, then offer the next queued one.
  always @(posedge clk) begin : drive
    line_cmd_t acc, nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
      line_on  = 1'b0;
      maj_pos  = '0;
      maj_stop = '0;
      min_pos  = '0;
      maj_d    = '0;
      min_d    = '0;
      err_term = '0;
      min_down = 1'b0;
      steep    = 1'b0;
      octant   = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        acc.op      = op_t'(in_ch.operation);
        acc.x_start = in_ch.x_start;
        acc.y_start = in_ch.y_start;
        acc.x_end   = in_ch.x_end;
        acc.y_end   = in_ch.y_end;
        acc.follow  = in_ch.follow_octant;
        if (acc.op == OP_START) raster_begin(acc);
        else raster_advance();
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (line_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = line_cmds.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.operation     <= nxt.op;
          in_ch.x_start       <= nxt.x_start;
          in_ch.y_start       <= nxt.y_start;
          in_ch.x_end         <= nxt.x_end;
          in_ch.y_end         <= nxt.y_end;
          in_ch.follow_octant <= nxt.follow;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver stall, counted here so the monitor only has to look at the count.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Receiver: compare each accepted pixel item with the oldest owed one.
  always @(posedge clk) begin : monitor
    pixel_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pixels_due.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected pixel expected none actual x=%0d y=%0d",
                   $time, out_ch.pixel_x, out_ch.pixel_y);
        end else begin
          want = pixels_due.pop_front();
          check_field("pixel_x", want.px, out_ch.pixel_x);
          check_field("pixel_y", want.py, out_ch.pixel_y);
          check_field("pixel_index", want.idx, out_ch.pixel_index);
          check_field("red", want.red, out_ch.red);
          check_field("green", want.green, out_ch.green);
          check_field("blue", want.blue, out_ch.blue);
          check_field("last_pixel", want.last, out_ch.last_pixel);
          check_field("out_of_frame", want.oof, out_ch.out_of_frame);
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    // Hold every input at a known value before the first edge.
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_START;
    in_ch.x_start       = '0;
    in_ch.y_start       = '0;
    in_ch.x_end         = '0;
    in_ch.y_end         = '0;
    in_ch.follow_octant = 1'b0;
    out_ch.ready        = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed lines under the reset frame size of 400 x 400.
    push_advances(1);                         // advance with nothing active: no pixel
    push_start(0, 0, 3, 1, 1'b1);             // shallow line, upright colors
    push_advances(3);
    push_start(1023, 1023, 1022, 1020, 1'b1); // steep and descending: untransposed output
    push_advances(3);
    push_start(5, 5, 5, 5, 1'b0);             // coincident endpoints leave no line
    push_advances(1);
    push_start(1023, 0, 1020, 2, 1'b0);       // transposed mode, dropped after one pixel
    push_advances(1);
    push_start(0, 1023, 2, 1023, 1'b1);       // new line abandons the old one; off the bottom
    push_advances(3);                         // last advance runs past the end
    push_start(500, 10, 502, 12, 1'b1);       // diagonal right of the frame
    push_advances(2);
    drain();

    // Frame of 1024 x 1024, covering every coordinate; sender mostly busy, receiver mostly stalled.
    write_reg(REG_FRAME_WIDTH, 11'd1024);
    write_reg(REG_FRAME_HEIGHT, 11'd1024);
    src_idle_pct = 14;
    snk_idle_pct = 78;
    run_phase(250, 1'b0);

    // Smallest non-empty frame; roles swapped.
    write_reg(REG_FRAME_WIDTH, 11'd1);
    write_reg(REG_FRAME_HEIGHT, 11'd1);
    src_idle_pct = 78;
    snk_idle_pct = 14;
    run_phase(250, 1'b0);

    // Zero width: every pixel lands outside the frame. No idling from here on.
    write_reg(REG_FRAME_WIDTH, 11'd0);
    write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(1, 1024)));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_phase(60, 1'b0);

    // Random frame, with a long receiver stall to back the block up.
    write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(1, 1024)));
    write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(1, 1024)));
    run_phase(190, 1'b1);

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> bresenham_line_rasterizer_top.f
rtl/blr_pkg.sv
rtl/blr_ifs.sv
rtl/blr_core.sv
rtl/blr_outq.sv
rtl/bresenham_line_rasterizer_top.sv
rtl/blr_checker.sv
tb/tb_bresenham_line_rasterizer_top.sv
